// ===== sv/ipvt_pkg.sv =====
// ----------------------------------------------------------------------------
// ipvt_pkg
// Shared types and codes of the IPv4-to-VLAN table: word formats, table entry,
// status codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ipvt_pkg;

    typedef struct packed {
        logic        mode;
        logic [31:0] ip_address;
        logic [11:0] vlan_id;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] found_vlan;
        logic [6:0]  entries_used;
    } t_out_word;

    typedef struct packed {
        logic [31:0] addr;
        logic [11:0] vlan;
    } t_entry;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_CONFLICT = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_FOUND    = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    // table read address source
    typedef enum logic [1:0] {
        RD_MID   = 2'd0,
        RD_LO    = 2'd1,
        RD_SHIFT = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        t_rd_sel    rd_sel;
        logic       srch_step;
        logic       shift_init;
        logic       wr_shift;
        logic       wr_new;
        logic       done;
        logic [2:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_lookup;
        logic lo_lt_hi;
        logic lo_lt_cnt;
        logic probe_less;
        logic probe_addr_eq;
        logic probe_vlan_eq;
        logic full;
        logic shift_end;
    } t_dp_sts;

endpackage

// ===== sv/ipvt_datapath.sv =====
// ----------------------------------------------------------------------------
// ipvt_datapath
// Sorted table memory, search bounds, shift index, entry count and the
// registered result word.
// ----------------------------------------------------------------------------
module ipvt_datapath
    import ipvt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_word,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_valid,
    output t_out_word o_word
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_entry         r_mem [TABLE_DEPTH];
    t_entry         r_rd_data;
    t_in_word       r_item;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [CW-1:0]  r_lo;
    logic [CW-1:0]  r_hi;
    logic [CW-1:0]  r_idx;
    logic [CW-1:0]  mid;
    logic [CW-1:0]  idx_m1;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    t_entry         wr_data;
    logic [CW+6:0]  cnt_ext;
    logic           r_valid;
    t_out_word      r_word;

    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign idx_m1 = r_idx - CW'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_MID:   rd_addr = mid[AW-1:0];
            RD_LO:    rd_addr = r_lo[AW-1:0];
            RD_SHIFT: rd_addr = idx_m1[AW-1:0];
            default:  rd_addr = mid[AW-1:0];
        endcase
    end

    assign wr_addr = i_cmd.wr_new ? r_lo[AW-1:0] : r_idx[AW-1:0];
    assign wr_data = i_cmd.wr_new ? t_entry'{addr: r_item.ip_address, vlan: r_item.vlan_id}
                                  : r_rd_data;

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new || i_cmd.wr_shift) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign n_count = i_cmd.wr_new ? r_count + CW'(1) : r_count;
    assign cnt_ext = {7'd0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= i_cmd.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_word;
            r_lo   <= '0;
            r_hi   <= r_count;
        end else if (i_cmd.srch_step) begin
            if (o_sts.probe_less) begin
                r_lo <= mid + CW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.shift_init) begin
            r_idx <= r_count;
        end else if (i_cmd.wr_shift) begin
            r_idx <= idx_m1;
        end
        if (i_cmd.done) begin
            r_word.status       <= i_cmd.status;
            r_word.found_vlan   <= (i_cmd.status == ST_FOUND) ? r_rd_data.vlan : 12'd0;
            r_word.entries_used <= cnt_ext[6:0];
        end
    end

    assign o_sts.is_lookup     = (r_item.mode == MODE_LOOKUP);
    assign o_sts.lo_lt_hi      = (r_lo < r_hi);
    assign o_sts.lo_lt_cnt     = (r_lo < r_count);
    assign o_sts.probe_less    = (r_rd_data.addr < r_item.ip_address);
    assign o_sts.probe_addr_eq = (r_rd_data.addr == r_item.ip_address);
    assign o_sts.probe_vlan_eq = (r_rd_data.vlan == r_item.vlan_id);
    assign o_sts.full          = (r_count == CW'(TABLE_DEPTH));
    assign o_sts.shift_end     = (r_idx == r_lo);

    assign o_valid = r_valid;
    assign o_word  = r_word;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_add_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_new |-> !o_sts.full && o_sts.shift_end)
        else $error("new entry written into full table or before shift finished");

    a_add_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_new |=> r_count == $past(r_count) + CW'(1))
        else $error("entry count not advanced on add");

    a_step_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.srch_step |-> r_lo < r_hi)
        else $error("search step on empty range");

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for two cycles");
`endif

endmodule

// ===== sv/ipvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipvt_ctrl
// Sequencer for the table: binary search probes, hit check, ordered shift on
// insert and the final result code.
// ----------------------------------------------------------------------------
module ipvt_ctrl
    import ipvt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PROBE,
        S_CHECK,
        S_SHIFT,
        S_SHF_WR,
        S_INS_WR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   resolve;
    logic   hit;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        resolve = 1'b0;
        hit     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_sts.lo_lt_hi) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_MID;
                    n_state      = S_PROBE;
                end else if (i_sts.lo_lt_cnt) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LO;
                    n_state      = S_CHECK;
                end else begin
                    resolve = 1'b1;
                end
            end
            S_PROBE: begin
                o_cmd.srch_step = 1'b1;
                n_state         = S_SEARCH;
            end
            S_CHECK: begin
                resolve = 1'b1;
                hit     = i_sts.probe_addr_eq;
            end
            S_SHIFT: begin
                if (i_sts.shift_end) begin
                    n_state = S_INS_WR;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_SHIFT;
                    n_state      = S_SHF_WR;
                end
            end
            S_SHF_WR: begin
                o_cmd.wr_shift = 1'b1;
                n_state        = S_SHIFT;
            end
            S_INS_WR: begin
                o_cmd.wr_new = 1'b1;
                o_cmd.done   = 1'b1;
                o_cmd.status = ST_ADDED;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (resolve) begin
            if (i_sts.is_lookup) begin
                o_cmd.done   = 1'b1;
                o_cmd.status = hit ? ST_FOUND : ST_NOTFOUND;
                n_state      = S_IDLE;
            end else if (hit) begin
                o_cmd.done   = 1'b1;
                o_cmd.status = i_sts.probe_vlan_eq ? ST_DUP : ST_CONFLICT;
                n_state      = S_IDLE;
            end else if (i_sts.full) begin
                o_cmd.done   = 1'b1;
                o_cmd.status = ST_FULL;
                n_state      = S_IDLE;
            end else begin
                o_cmd.shift_init = 1'b1;
                n_state          = S_SHIFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== sv/ip_to_vlan_table.sv =====
// ----------------------------------------------------------------------------
// ip_to_vlan_table
// Sorted IPv4 address to VLAN table with insert and binary-search lookup.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Busy then stays high
// until the result is produced. The result is shown for one cycle with
// o_valid, in the first cycle in which busy is low again, and the next word
// may be taken in that same cycle. The receiver cannot stall. The table sits
// in a single-port-read memory with a registered read, so each binary search
// probe passes through S_SEARCH, which issues the read, and S_PROBE, which
// narrows the bounds. An insert that adds an entry moves each larger entry
// up to open its slot, each move reading in S_SHIFT and writing in S_SHF_WR,
// then makes the last slot check in S_SHIFT and writes the new entry in
// S_INS_WR. Entries are kept in ascending address order; the table holds
// TABLE_DEPTH entries.
// ----------------------------------------------------------------------------
module ip_to_vlan_table
    import ipvt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_valid,
    output t_out_word o_word
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    ipvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ipvt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_word),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

endmodule
